[hw/rtl/xeu_pkg.sv]
package xeu_pkg;

    // Predefined entity names (without the leading ampersand), their lengths and values
    localparam int NUM_ENT    = 5;
    localparam int NAME_MAX   = 6;
    localparam int HELD_DEPTH = 4;

    localparam logic [7:0] CHAR_AMP = 8'h26;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [0:NUM_ENT-1][0:NAME_MAX-1][7:0] ENT_NAME = '{
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00},   // lt;
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00},   // gt;
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b, 8'h00},   // quot;
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00, 8'h00},   // amp;
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b, 8'h00}    // apos;
    };
    localparam logic [0:NUM_ENT-1][2:0] ENT_LEN  = '{3'd3, 3'd3, 3'd5, 3'd4, 3'd5};
    localparam logic [0:NUM_ENT-1][7:0] ENT_CHAR = '{8'h3c, 8'h3e, 8'h22, 8'h26, 8'h27};

    // Input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } xeu_in_t;

    // Result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
        logic       bad_tail;
    } xeu_out_t;

    // What follows an optional literal flush
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_ERR
    } xeu_tail_t;

    // One classified input byte: flush '&' plus held bytes, then a tail
    typedef struct packed {
        logic                      flush;
        logic [2:0]                flush_cnt;
        logic [HELD_DEPTH-1:0][7:0] chars;
        xeu_tail_t                 tail;
        logic [7:0]                tail_byte;
        logic                      last;
    } xeu_job_t;

endpackage

[hw/rtl/xeu_front.sv]
module xeu_front
    import xeu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  xeu_in_t  item,
    output logic     job_push,
    output xeu_job_t job
);

    logic                       pending_reg, pending_next;
    logic [2:0]                 count_reg, count_next;
    logic [NUM_ENT-1:0]         mask_reg, mask_next;
    logic [HELD_DEPTH-1:0][7:0] held_reg, held_next;

    logic [NUM_ENT-1:0] match;
    logic               done;
    logic [7:0]         done_char;
    logic [7:0]         b;
    logic               last;

    assign b    = item.in_byte;
    assign last = item.in_last;

    // Candidate match against every entity still consistent with held bytes
    always_comb
    begin
        match     = '0;
        done      = 1'b0;
        done_char = CHAR_NUL;
        for (int k = 0; k < NUM_ENT; k++)
        begin
            match[k] = mask_reg[k] && (count_reg < ENT_LEN[k])
                       && (ENT_NAME[k][count_reg] == b);
            if (match[k] && (({1'b0, count_reg} + 4'd1) == {1'b0, ENT_LEN[k]}))
            begin
                done      = 1'b1;
                done_char = ENT_CHAR[k];
            end
        end
    end

    // Classify the byte, build the job and the next decoder state
    always_comb
    begin
        logic do_fresh;
        do_fresh      = 1'b0;
        pending_next  = pending_reg;
        count_next    = count_reg;
        mask_next     = mask_reg;
        held_next     = held_reg;
        job.flush     = 1'b0;
        job.flush_cnt = count_reg;
        job.chars     = held_reg;
        job.tail      = TAIL_NONE;
        job.tail_byte = b;
        job.last      = last;

        if (!pending_reg)
        begin
            do_fresh = 1'b1;
        end
        else if (done)
        begin
            job.tail      = TAIL_BYTE;
            job.tail_byte = done_char;
            pending_next  = 1'b0;
            count_next    = '0;
        end
        else if ((|match) && (count_reg < 3'(HELD_DEPTH)))
        begin
            held_next[count_reg[1:0]] = b;
            count_next = count_reg + 3'd1;
            mask_next  = match;
            if (last)
            begin
                job.flush     = 1'b1;
                job.flush_cnt = count_reg + 3'd1;
                job.chars     = held_next;
            end
        end
        else
        begin
            job.flush    = 1'b1;
            pending_next = 1'b0;
            count_next   = '0;
            do_fresh     = 1'b1;
        end

        // Byte handled outside an entity
        if (do_fresh)
        begin
            if (b == CHAR_AMP)
            begin
                if (last)
                begin
                    job.tail = TAIL_ERR;
                end
                else
                begin
                    pending_next = 1'b1;
                    count_next   = '0;
                    mask_next    = '1;
                end
            end
            else
            begin
                job.tail = TAIL_BYTE;
            end
        end

        if (last)
        begin
            pending_next = 1'b0;
            count_next   = '0;
        end

        job_push = accept && (job.flush || (job.tail != TAIL_NONE));
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            count_reg   <= '0;
            mask_reg    <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
            mask_reg    <= mask_next;
        end
    end

    // Held bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

[hw/rtl/xeu_job_fifo.sv]
module xeu_job_fifo
    import xeu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  xeu_job_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output xeu_job_t rd_data,
    output logic     nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xeu_job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/xeu_back.sv]
module xeu_back
    import xeu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  xeu_job_t job,
    input  logic     job_avail,
    output logic     job_pop,
    output logic     empty,
    input  logic     pop,
    output xeu_out_t result
);

    logic [2:0] idx_reg;
    logic       out_valid_reg;
    xeu_out_t   out_reg;

    logic [2:0] n_flush;
    logic [2:0] total;
    logic [2:0] char_sel;
    xeu_out_t   elem;
    logic       load;
    logic       pop_fire;

    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign pop_fire = pop && out_valid_reg;
    assign load     = job_avail && (!out_valid_reg || pop_fire);
    assign job_pop  = load && elem.run_end;

    // Pick the beat at the current position of the head job
    always_comb
    begin
        n_flush  = job.flush ? (job.flush_cnt + 3'd1) : 3'd0;
        total    = n_flush + ((job.tail != TAIL_NONE) ? 3'd1 : 3'd0);
        char_sel = idx_reg - 3'd1;
        elem.bad_tail = 1'b0;
        if (idx_reg < n_flush)
        begin
            elem.out_byte = (idx_reg == 3'd0) ? CHAR_AMP : job.chars[char_sel[1:0]];
        end
        else if (job.tail == TAIL_ERR)
        begin
            elem.out_byte = CHAR_NUL;
            elem.bad_tail = 1'b1;
        end
        else
        begin
            elem.out_byte = job.tail_byte;
        end
        elem.run_end    = (idx_reg == (total - 3'd1));
        elem.stream_end = elem.run_end && job.last;
    end

    // Position within the job and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= elem.run_end ? 3'd0 : idx_reg + 3'd1;
                out_valid_reg <= 1'b1;
            end
            else if (pop_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= elem;
        end
    end

endmodule

[hw/rtl/xml_entity_unescape_stream_top.sv]
// XML entity decoder: takes one byte per cycle and replaces &lt; &gt; &quot;
// &amp; &apos; by their characters. An input beat is taken every cycle while
// full is low; full rises only when the JOB_DEPTH-entry job queue between the
// classifier and the output sequencer is full. The output side delivers one
// result per cycle while pop is high, so a byte that causes k results (up to
// six, when a broken prefix is flushed as '&' plus the held bytes) holds the
// output sequencer until all k are out; ordinary bytes pass one per cycle.
// Bytes held inside an entity prefix give no result until the entity ends or
// breaks. A lone '&' as the last byte gives a result with bad_tail set.
module xml_entity_unescape_stream_top
    import xeu_pkg::*;
#(
    parameter int JOB_DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  xeu_in_t  item,
    output logic     empty,
    input  logic     pop,
    output xeu_out_t result
);

    logic     accept;
    logic     job_push;
    xeu_job_t job_in;
    xeu_job_t job_head;
    logic     job_avail;
    logic     job_pop;

    assign accept = push && !full;

    // Classifier
    xeu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .job_push (job_push),
        .job      (job_in)
    );

    // Job queue
    xeu_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .full     (full),
        .rd_en    (job_pop),
        .rd_data  (job_head),
        .nonempty (job_avail)
    );

    // Output sequencer
    xeu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_avail (job_avail),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
